### hw/rtl/two_link_inverse_kinematics_macros.svh
// assertion helpers shared by the asserting files
`ifndef TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLIK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tlik_pkg.sv
package tlik_pkg;

    // field widths
    localparam int XY_W = 20;
    localparam int L_W  = 19;
    localparam int SH_W = 18;
    localparam int EL_W = 17;

    // restoring divider for the elbow cosine, one quotient bit per stage
    localparam int ANUM_W    = 40;
    localparam int DEN_W     = 39;
    localparam int DIV_STEPS = 30;

    // root of 2^60 - c^2, one result bit per stage
    localparam int SQ_W       = 62;
    localparam int SQRT_STEPS = 31;

    // vectoring unit
    localparam int OP_W         = 52;
    localparam int CW           = 54;
    localparam int Z_W          = 26;
    localparam int NORM_STEPS   = 6;
    localparam int NORM_TOP     = 41;
    localparam int CORDIC_STEPS = 23;
    localparam int CORDIC_LAT   = 1 + NORM_STEPS + 1 + CORDIC_STEPS;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd5898240;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNREACH = 2'd1,
        STATUS_LIMIT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_LINK1     = 3'd0,
        REG_LINK2     = 3'd1,
        REG_SH_MIN    = 3'd2,
        REG_SH_MAX    = 3'd3,
        REG_EL_MIN    = 3'd4,
        REG_EL_MAX    = 3'd5
    } reg_idx_t;

    // arctangent of 2^-i in degrees * 2^16
    function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
        case (i)
            0:  return 26'sd2949120;
            1:  return 26'sd1740967;
            2:  return 26'sd919879;
            3:  return 26'sd466945;
            4:  return 26'sd234379;
            5:  return 26'sd117304;
            6:  return 26'sd58666;
            7:  return 26'sd29335;
            8:  return 26'sd14668;
            9:  return 26'sd7334;
            10: return 26'sd3667;
            11: return 26'sd1833;
            12: return 26'sd917;
            13: return 26'sd458;
            14: return 26'sd229;
            15: return 26'sd115;
            16: return 26'sd57;
            17: return 26'sd29;
            18: return 26'sd14;
            19: return 26'sd7;
            20: return 26'sd4;
            21: return 26'sd2;
            22: return 26'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

### hw/rtl/tlik_div.sv
module tlik_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [tlik_pkg::ANUM_W-1:0]          in_num,
    input  logic [tlik_pkg::DEN_W-1:0]           in_den,
    output logic                                 out_valid,
    output logic [tlik_pkg::DIV_STEPS-1:0]       out_quo
);

    logic                              v_reg [tlik_pkg::DIV_STEPS];
    logic [tlik_pkg::ANUM_W-1:0]       r_reg [tlik_pkg::DIV_STEPS];
    logic [tlik_pkg::DIV_STEPS-1:0]    q_reg [tlik_pkg::DIV_STEPS];
    logic [tlik_pkg::DEN_W-1:0]        d_reg [tlik_pkg::DIV_STEPS];

    for (genvar k = 0; k < tlik_pkg::DIV_STEPS; k++) begin : g_step
        logic                           v_in;
        logic [tlik_pkg::ANUM_W-1:0]    r_in;
        logic [tlik_pkg::DIV_STEPS-1:0] q_in;
        logic [tlik_pkg::DEN_W-1:0]     d_in;
        logic [tlik_pkg::ANUM_W:0]      r2;
        logic                           ge;
        logic [tlik_pkg::ANUM_W-1:0]    r_next;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_num;
            assign q_in = '0;
            assign d_in = in_den;
        end else begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
        end

        // shift in one bit, subtract the divisor when it fits
        assign r2     = {r_in, 1'b0};
        assign ge     = r2 >= {2'b00, d_in};
        assign r_next = ge ? tlik_pkg::ANUM_W'(r2 - {2'b00, d_in}) : r2[tlik_pkg::ANUM_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= r_next;
                q_reg[k] <= {q_in[tlik_pkg::DIV_STEPS-2:0], ge};
                d_reg[k] <= d_in;
            end
        end
    end

    assign out_valid = v_reg[tlik_pkg::DIV_STEPS-1];
    assign out_quo   = q_reg[tlik_pkg::DIV_STEPS-1];

endmodule

### hw/rtl/tlik_sqrt.sv
module tlik_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tlik_pkg::SQ_W-1:0]     in_rad,
    output logic                          out_valid,
    output logic [tlik_pkg::SQRT_STEPS-1:0] out_root
);

    logic                          v_reg [tlik_pkg::SQRT_STEPS];
    logic [tlik_pkg::SQ_W-1:0]     n_reg [tlik_pkg::SQRT_STEPS];
    logic [tlik_pkg::SQ_W-1:0]     r_reg [tlik_pkg::SQRT_STEPS];

    for (genvar k = 0; k < tlik_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [tlik_pkg::SQ_W-1:0] BIT =
            tlik_pkg::SQ_W'(1) << (2 * (tlik_pkg::SQRT_STEPS - 1 - k));
        logic                       v_in;
        logic [tlik_pkg::SQ_W-1:0]  n_in;
        logic [tlik_pkg::SQ_W-1:0]  r_in;
        logic [tlik_pkg::SQ_W-1:0]  trial;
        logic                       ge;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = in_rad;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = v_reg[k-1];
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        // one result bit per stage
        assign trial = r_in + BIT;
        assign ge    = n_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= ge ? n_in - trial : n_in;
                r_reg[k] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
            end
        end
    end

    assign out_valid = v_reg[tlik_pkg::SQRT_STEPS-1];
    assign out_root  = r_reg[tlik_pkg::SQRT_STEPS-1][tlik_pkg::SQRT_STEPS-1:0];

endmodule

### hw/rtl/tlik_cordic.sv
module tlik_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [tlik_pkg::OP_W-1:0]  in_sy,
    input  logic signed [tlik_pkg::OP_W-1:0]  in_cx,
    output logic                              out_valid,
    output logic signed [tlik_pkg::Z_W-1:0]   out_z
);

    localparam int TOT  = tlik_pkg::CORDIC_LAT;
    localparam int QS   = tlik_pkg::NORM_STEPS + 1;
    localparam int CW   = tlik_pkg::CW;

    logic                       v_reg  [TOT];
    logic                       zf_reg [TOT];
    logic signed [CW-1:0]       sy_reg [TOT];
    logic signed [CW-1:0]       cx_reg [TOT];
    logic [tlik_pkg::OP_W-1:0]  m_reg  [tlik_pkg::NORM_STEPS+1];
    logic signed [tlik_pkg::Z_W-1:0] z_reg [tlik_pkg::CORDIC_STEPS+1];

    logic [tlik_pkg::OP_W-1:0]  mag_sy;
    logic [tlik_pkg::OP_W-1:0]  mag_cx;
    logic [tlik_pkg::OP_W-1:0]  mag_or;

    // valid and zero-operand flag travel along every stage
    for (genvar k = 0; k < TOT; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
        if (k > 0) begin : g_zf
            always_ff @(posedge aclk) begin
                if (en) begin
                    zf_reg[k] <= zf_reg[k-1];
                end
            end
        end
    end

    // input stage: widen and OR the two magnitudes
    assign mag_sy = in_sy[tlik_pkg::OP_W-1] ? tlik_pkg::OP_W'(-in_sy) : in_sy;
    assign mag_cx = in_cx[tlik_pkg::OP_W-1] ? tlik_pkg::OP_W'(-in_cx) : in_cx;
    assign mag_or = mag_sy | mag_cx;

    always_ff @(posedge aclk) begin
        if (en) begin
            sy_reg[0] <= CW'(in_sy);
            cx_reg[0] <= CW'(in_cx);
            m_reg[0]  <= mag_or;
            zf_reg[0] <= mag_or == '0;
        end
    end

    // prescale: binary search on the leading one, 32 down to 1
    for (genvar k = 1; k <= tlik_pkg::NORM_STEPS; k++) begin : g_norm
        localparam int AMT = 1 << (tlik_pkg::NORM_STEPS - k);
        logic do_shift;
        assign do_shift = (m_reg[k-1] >> (tlik_pkg::NORM_TOP - AMT)) == '0;
        always_ff @(posedge aclk) begin
            if (en) begin
                sy_reg[k] <= do_shift ? sy_reg[k-1] <<< AMT : sy_reg[k-1];
                cx_reg[k] <= do_shift ? cx_reg[k-1] <<< AMT : cx_reg[k-1];
                m_reg[k]  <= do_shift ? m_reg[k-1] << AMT : m_reg[k-1];
            end
        end
    end

    // quarter turn into the right half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            if (cx_reg[QS-1] < 0) begin
                if (sy_reg[QS-1] >= 0) begin
                    cx_reg[QS] <= sy_reg[QS-1];
                    sy_reg[QS] <= -cx_reg[QS-1];
                    z_reg[0]   <= tlik_pkg::QUARTER_TURN;
                end else begin
                    cx_reg[QS] <= -sy_reg[QS-1];
                    sy_reg[QS] <= cx_reg[QS-1];
                    z_reg[0]   <= -tlik_pkg::QUARTER_TURN;
                end
            end else begin
                cx_reg[QS] <= cx_reg[QS-1];
                sy_reg[QS] <= sy_reg[QS-1];
                z_reg[0]   <= '0;
            end
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < tlik_pkg::CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [tlik_pkg::Z_W-1:0] ANG = tlik_pkg::atan_entry(i);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = sy_reg[QS+i] >>> i;
        assign dy = cx_reg[QS+i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sy_reg[QS+i] >= 0) begin
                    cx_reg[QS+i+1] <= cx_reg[QS+i] + dx;
                    sy_reg[QS+i+1] <= sy_reg[QS+i] - dy;
                    z_reg[i+1]     <= z_reg[i] + ANG;
                end else begin
                    cx_reg[QS+i+1] <= cx_reg[QS+i] - dx;
                    sy_reg[QS+i+1] <= sy_reg[QS+i] + dy;
                    z_reg[i+1]     <= z_reg[i] - ANG;
                end
            end
        end
    end

    assign out_valid = v_reg[TOT-1];
    assign out_z     = zf_reg[TOT-1] ? '0 : z_reg[tlik_pkg::CORDIC_STEPS];

endmodule

### hw/rtl/two_link_inverse_kinematics.sv
// channel  | dir | handshake                 | word
// s_       | in  | s_tvalid / s_tready       | tdata: target_x, target_y; tuser: elbow_down
// m_       | out | m_tvalid / m_tready       | tdata: shoulder_angle, elbow_angle; tuser: status
// apb      | in  | psel / penable / pready   | link lengths and joint limits
//
// one word per cycle sustained while the output word is not held
// the pipeline includes the 30-stage divider, 31-stage root and 31-stage vectoring units
// every stage advances together; a held output word stalls the whole pipeline
// aresetn is synchronous, clears valid bits and resets the configuration registers to their defaults
`include "two_link_inverse_kinematics_macros.svh"

module two_link_inverse_kinematics (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [19:0] target_x, [39:20] target_y
    input  logic [0:0]  s_tuser,   // [0] elbow_down
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [17:0] shoulder_angle, [34:18] elbow_angle, zero above
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic               down;
        logic               neg;
        logic               unreach;
        logic               full;
    } side_t;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic               down;
        logic               unreach;
        logic signed [31:0] c;
    } side2_t;

    logic en;

    // configuration registers
    logic [18:0]        link1_reg, link2_reg;
    logic signed [17:0] sh_min_reg, sh_max_reg;
    logic signed [16:0] el_min_reg, el_max_reg;
    tlik_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = tlik_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link1_reg  <= 19'd25600;
            link2_reg  <= 19'd25600;
            sh_min_reg <= -18'sd46080;
            sh_max_reg <= 18'sd46080;
            el_min_reg <= -17'sd46080;
            el_max_reg <= 17'sd46080;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                tlik_pkg::REG_LINK1:  link1_reg  <= pwdata[18:0];
                tlik_pkg::REG_LINK2:  link2_reg  <= pwdata[18:0];
                tlik_pkg::REG_SH_MIN: sh_min_reg <= pwdata[17:0];
                tlik_pkg::REG_SH_MAX: sh_max_reg <= pwdata[17:0];
                tlik_pkg::REG_EL_MIN: el_min_reg <= pwdata[16:0];
                tlik_pkg::REG_EL_MAX: el_max_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tlik_pkg::REG_LINK1:  prdata = 32'(link1_reg);
            tlik_pkg::REG_LINK2:  prdata = 32'(link2_reg);
            tlik_pkg::REG_SH_MIN: prdata = 32'($unsigned(sh_min_reg));
            tlik_pkg::REG_SH_MAX: prdata = 32'($unsigned(sh_max_reg));
            tlik_pkg::REG_EL_MIN: prdata = 32'($unsigned(el_min_reg));
            tlik_pkg::REG_EL_MAX: prdata = 32'($unsigned(el_max_reg));
            default:              prdata = '0;
        endcase
    end

    // whole pipeline moves unless the output word is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: squares and link products
    logic signed [19:0] in_x, in_y;
    logic signed [39:0] x_sq, y_sq;
    logic [37:0]        l1_sq, l2_sq, l12;
    logic               v1_reg;
    logic signed [19:0] x1_reg, y1_reg;
    logic               down1_reg;
    logic [38:0]        xx1_reg, yy1_reg;
    logic [37:0]        l1sq1_reg, l2sq1_reg, l12_1_reg;

    assign in_x  = s_tdata[19:0];
    assign in_y  = s_tdata[39:20];
    assign x_sq  = in_x * in_x;
    assign y_sq  = in_y * in_y;
    assign l1_sq = link1_reg * link1_reg;
    assign l2_sq = link2_reg * link2_reg;
    assign l12   = link1_reg * link2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            down1_reg <= s_tuser[0];
            xx1_reg   <= x_sq[38:0];
            yy1_reg   <= y_sq[38:0];
            l1sq1_reg <= l1_sq;
            l2sq1_reg <= l2_sq;
            l12_1_reg <= l12;
        end
    end

    // stage 2: law of cosines numerator and denominator
    logic signed [40:0] num_next;
    logic               v2_reg;
    logic signed [19:0] x2_reg, y2_reg;
    logic               down2_reg, neg2_reg;
    logic [39:0]        anum2_reg;
    logic [38:0]        den2_reg;

    assign num_next = $signed({2'b00, xx1_reg}) + $signed({2'b00, yy1_reg})
                    - $signed({3'b000, l1sq1_reg}) - $signed({3'b000, l2sq1_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            down2_reg <= down1_reg;
            neg2_reg  <= num_next < 0;
            anum2_reg <= num_next < 0 ? 40'(-num_next) : num_next[39:0];
            den2_reg  <= {l12_1_reg, 1'b0};
        end
    end

    // stage 3: excess of the numerator over the denominator
    logic [40:0]        diff;
    logic               v3_reg;
    side_t              sd3_reg;
    logic [39:0]        anum3_reg;
    logic [38:0]        den3_reg;
    logic               gt3_reg, big3_reg;
    logic [22:0]        dlo3_reg;

    assign diff = {1'b0, anum2_reg} - {2'b00, den2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            sd3_reg.x       <= x2_reg;
            sd3_reg.y       <= y2_reg;
            sd3_reg.down    <= down2_reg;
            sd3_reg.neg     <= neg2_reg;
            sd3_reg.unreach <= den2_reg == '0;
            sd3_reg.full    <= anum2_reg >= {1'b0, den2_reg};
            anum3_reg       <= anum2_reg;
            den3_reg        <= den2_reg;
            gt3_reg         <= anum2_reg > {1'b0, den2_reg};
            big3_reg        <= diff[39:23] != '0;
            dlo3_reg        <= diff[22:0];
        end
    end

    // stage 4: scaled excess for the tolerance test
    logic               v4_reg;
    side_t              sd4_reg;
    logic [39:0]        anum4_reg;
    logic [38:0]        den4_reg;
    logic               gt4_reg, big4_reg;
    logic [39:0]        prod4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd4_reg   <= sd3_reg;
            anum4_reg <= anum3_reg;
            den4_reg  <= den3_reg;
            gt4_reg   <= gt3_reg;
            big4_reg  <= big3_reg;
            prod4_reg <= dlo3_reg * 17'd100000;
        end
    end

    // stage 5: reach decision
    logic               v5_reg;
    side_t              sd5_reg;
    logic [39:0]        anum5_reg;
    logic [38:0]        den5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd5_reg.x       <= sd4_reg.x;
            sd5_reg.y       <= sd4_reg.y;
            sd5_reg.down    <= sd4_reg.down;
            sd5_reg.neg     <= sd4_reg.neg;
            sd5_reg.full    <= sd4_reg.full;
            sd5_reg.unreach <= sd4_reg.unreach
                             || (gt4_reg && (big4_reg || prod4_reg > {1'b0, den4_reg}));
            anum5_reg       <= anum4_reg;
            den5_reg        <= den4_reg;
        end
    end

    // cosine divider with side data alongside
    logic        vd;
    logic [29:0] quo;
    side_t       sdd_reg [tlik_pkg::DIV_STEPS];

    tlik_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (anum5_reg),
        .in_den    (den5_reg),
        .out_valid (vd),
        .out_quo   (quo)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sdd_reg[0] <= sd5_reg;
            for (int k = 1; k < tlik_pkg::DIV_STEPS; k++) begin
                sdd_reg[k] <= sdd_reg[k-1];
            end
        end
    end

    // stage 6: signed cosine, clamped to one
    logic               v6_reg;
    side2_t             sd6_reg;
    logic [30:0]        q6_reg;
    side_t              sdd_last;
    logic [30:0]        q_sel;

    assign sdd_last = sdd_reg[tlik_pkg::DIV_STEPS-1];
    assign q_sel    = sdd_last.full ? 31'h4000_0000 : {1'b0, quo};

    always_ff @(posedge aclk) begin
        if (en) begin
            q6_reg          <= q_sel;
            sd6_reg.x       <= sdd_last.x;
            sd6_reg.y       <= sdd_last.y;
            sd6_reg.down    <= sdd_last.down;
            sd6_reg.unreach <= sdd_last.unreach;
            sd6_reg.c       <= sdd_last.neg ? -$signed({1'b0, q_sel}) : $signed({1'b0, q_sel});
        end
    end

    // stage 7: cosine squared
    logic               v7_reg;
    side2_t             sd7_reg;
    logic [61:0]        qq7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd7_reg <= sd6_reg;
            qq7_reg <= q6_reg * q6_reg;
        end
    end

    // stage 8: radicand one minus cosine squared
    logic               v8_reg;
    side2_t             sd8_reg;
    logic [61:0]        rad8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd8_reg  <= sd7_reg;
            rad8_reg <= (62'd1 << 60) - qq7_reg;
        end
    end

    // sine root with side data alongside
    logic        vs;
    logic [30:0] root;
    side2_t      sds_reg [tlik_pkg::SQRT_STEPS];

    tlik_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_rad    (rad8_reg),
        .out_valid (vs),
        .out_root  (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sds_reg[0] <= sd8_reg;
            for (int k = 1; k < tlik_pkg::SQRT_STEPS; k++) begin
                sds_reg[k] <= sds_reg[k-1];
            end
        end
    end

    // stage 9: signed sine for the chosen elbow
    logic               v9_reg;
    side2_t             sd9_reg;
    logic signed [31:0] s9_reg;
    side2_t             sds_last;

    assign sds_last = sds_reg[tlik_pkg::SQRT_STEPS-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sd9_reg <= sds_last;
            s9_reg  <= sds_last.down ? -$signed({1'b0, root}) : $signed({1'b0, root});
        end
    end

    // stage 10: second link times sine and cosine
    logic                               v10_reg;
    side2_t                             sd10_reg;
    logic signed [31:0]                 s10_reg;
    logic signed [tlik_pkg::OP_W-1:0]   l2s10_reg, l2c10_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd10_reg  <= sd9_reg;
            s10_reg   <= s9_reg;
            l2s10_reg <= $signed({1'b0, link2_reg}) * s9_reg;
            l2c10_reg <= $signed({1'b0, link2_reg}) * sd9_reg.c;
        end
    end

    // stage 11: operands of the three arctangents
    logic                               v11_reg;
    logic                               un11_reg;
    logic signed [tlik_pkg::OP_W-1:0]   a_sy11_reg, a_cx11_reg;
    logic signed [tlik_pkg::OP_W-1:0]   b_sy11_reg, b_cx11_reg;
    logic signed [tlik_pkg::OP_W-1:0]   c_sy11_reg, c_cx11_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            un11_reg   <= sd10_reg.unreach;
            a_sy11_reg <= tlik_pkg::OP_W'(s10_reg);
            a_cx11_reg <= tlik_pkg::OP_W'(sd10_reg.c);
            b_sy11_reg <= tlik_pkg::OP_W'(sd10_reg.x);
            b_cx11_reg <= tlik_pkg::OP_W'(sd10_reg.y);
            c_sy11_reg <= l2s10_reg;
            c_cx11_reg <= $signed({3'b000, link1_reg, 30'd0}) + l2c10_reg;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= vd;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= vs;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // three vectoring units: elbow, target direction, arm offset
    logic                              va;
    logic signed [tlik_pkg::Z_W-1:0]   za, zb, zc;
    logic                              unc_reg [tlik_pkg::CORDIC_LAT];

    tlik_cordic u_cordic_elbow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v11_reg),
        .in_sy     (a_sy11_reg),
        .in_cx     (a_cx11_reg),
        .out_valid (va),
        .out_z     (za)
    );

    tlik_cordic u_cordic_target (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v11_reg),
        .in_sy     (b_sy11_reg),
        .in_cx     (b_cx11_reg),
        .out_valid (),
        .out_z     (zb)
    );

    tlik_cordic u_cordic_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v11_reg),
        .in_sy     (c_sy11_reg),
        .in_cx     (c_cx11_reg),
        .out_valid (),
        .out_z     (zc)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            unc_reg[0] <= un11_reg;
            for (int k = 1; k < tlik_pkg::CORDIC_LAT; k++) begin
                unc_reg[k] <= unc_reg[k-1];
            end
        end
    end

    // stage 12: joint angles rounded to deg*256
    logic signed [26:0] t1, sum1;
    logic signed [25:0] sum2;
    logic               v12_reg;
    logic               un12_reg;
    logic signed [18:0] j1_12_reg;
    logic signed [17:0] j2_12_reg;

    assign t1   = 27'(zb) - 27'(zc);
    assign sum1 = -t1 + 27'sd128;
    assign sum2 = za + 26'sd128;

    always_ff @(posedge aclk) begin
        if (en) begin
            un12_reg  <= unc_reg[tlik_pkg::CORDIC_LAT-1];
            j1_12_reg <= sum1[26:8];
            j2_12_reg <= sum2[25:8];
        end
    end

    // stage 13: limit check into the output register
    logic               in_limits;
    logic               v13_reg;
    tlik_pkg::status_t  st13_reg;
    logic [17:0]        sh13_reg;
    logic [16:0]        el13_reg;

    assign in_limits = j1_12_reg >= sh_min_reg && j1_12_reg <= sh_max_reg
                    && j2_12_reg >= el_min_reg && j2_12_reg <= el_max_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (un12_reg) begin
                st13_reg <= tlik_pkg::STATUS_UNREACH;
                sh13_reg <= '0;
                el13_reg <= '0;
            end else begin
                st13_reg <= in_limits ? tlik_pkg::STATUS_OK : tlik_pkg::STATUS_LIMIT;
                sh13_reg <= j1_12_reg[17:0];
                el13_reg <= j2_12_reg[16:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end else if (en) begin
            v12_reg <= va;
            v13_reg <= v12_reg;
        end
    end

    assign m_tvalid = v13_reg;
    assign m_tdata  = {5'd0, el13_reg, sh13_reg};
    assign m_tuser  = st13_reg;

    // checks
    `TLIK_ASSERT_IMP(a_unreach_zero, m_tvalid && m_tuser == tlik_pkg::STATUS_UNREACH, m_tdata == '0, "unreachable word carries nonzero angles")
    `TLIK_ASSERT_NXT(a_stall_freeze, !s_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while input side stalled")

endmodule
